@@ sv/i2cbw_pkg.sv @@
// Shared types, codes and the phase encoding of the I2C byte writer.
`timescale 1ns / 1ps
package i2cbw_pkg;

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_STOP  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    localparam logic [15:0] DELAY_RESET = 16'd500;
    localparam int unsigned PHASE_W = 5;
    localparam logic [PHASE_W-1:0] LAST_PHASE_COND  = 5'd2;
    localparam logic [PHASE_W-1:0] LAST_PHASE_WRITE = 5'd17;
    localparam logic [PHASE_W-1:0] ACK_PHASE        = 5'd16;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_STOP  = 2'd1,
        CMD_WRITE = 2'd2
    } t_cmd;

    typedef struct packed {
        t_cmd       cmd;
        logic [7:0] data;
        logic       ack_level;
    } t_cmd_entry;

    typedef struct packed {
        logic scl;
        logic sda;
        logic sda_released;
        logic acked;
        logic last;
    } t_phase;

    function automatic t_phase phase_bits(input t_cmd_entry e,
                                          input logic [PHASE_W-1:0] ph);
        t_phase p;
        p = '0;
        case (e.cmd)
            CMD_START: begin
                p.scl  = (ph != LAST_PHASE_COND);
                p.sda  = (ph == '0);
                p.last = (ph == LAST_PHASE_COND);
            end
            CMD_STOP: begin
                p.scl  = (ph != '0);
                p.sda  = (ph == LAST_PHASE_COND);
                p.last = (ph == LAST_PHASE_COND);
            end
            CMD_WRITE: begin
                if (ph < ACK_PHASE) begin
                    p.scl = ~ph[0];
                    p.sda = e.data[~ph[3:1]];
                end else begin
                    p.scl          = (ph == ACK_PHASE);
                    p.sda          = e.data[0];
                    p.sda_released = (ph == ACK_PHASE);
                    p.acked        = (ph == LAST_PHASE_WRITE) && !e.ack_level;
                    p.last         = (ph == LAST_PHASE_WRITE);
                end
            end
            default: p = '0;
        endcase
        return p;
    endfunction

endpackage

@@ sv/i2cbw_front.sv @@
// Command front end: decodes the opcode and queues valid commands.
`timescale 1ns / 1ps
module i2cbw_front import i2cbw_pkg::*; (
    input  logic       i_push,
    input  logic [1:0] i_op,
    input  logic [7:0] i_data,
    input  logic       i_ack_level,
    input  logic       i_q_full,
    output logic       o_full,
    output logic       o_q_wr,
    output t_cmd_entry o_q_entry
);

    logic w_valid_op;

    always_comb begin
        w_valid_op           = 1'b1;
        o_q_entry.cmd        = CMD_START;
        o_q_entry.data       = i_data;
        o_q_entry.ack_level  = i_ack_level;
        case (i_op)
            OP_START: o_q_entry.cmd = CMD_START;
            OP_STOP:  o_q_entry.cmd = CMD_STOP;
            OP_WRITE: o_q_entry.cmd = CMD_WRITE;
            default:  w_valid_op    = 1'b0;
        endcase
    end

    assign o_full = i_q_full;
    // unused opcode: beat is taken and dropped
    assign o_q_wr = i_push && !i_q_full && w_valid_op;

endmodule

@@ sv/i2cbw_cmd_fifo.sv @@
// Short command queue between the front end and the phase sequencer.
`timescale 1ns / 1ps
module i2cbw_cmd_fifo import i2cbw_pkg::*; #(
    parameter int unsigned DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_wr,
    input  t_cmd_entry i_wr_entry,
    input  logic       i_rd,
    output t_cmd_entry o_rd_entry,
    output logic       o_full,
    output logic       o_empty
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_cmd_entry       r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic             w_wr, w_rd;

    assign o_full     = (r_count == CW'(DEPTH));
    assign o_empty    = (r_count == '0);
    assign o_rd_entry = r_mem[r_rd_ptr];
    assign w_wr       = i_wr && !o_full;
    assign w_rd       = i_rd && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_wr) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_rd) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_wr && !w_rd) begin
            n_count = r_count + 1'b1;
        end else if (w_rd && !w_wr) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_wr_entry;
        end
    end

endmodule

@@ sv/i2cbw_seq.sv @@
// Phase sequencer: steps each command through its pin phases with hold timing.
`timescale 1ns / 1ps
module i2cbw_seq import i2cbw_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [15:0] i_delay,
    input  logic        i_q_empty,
    input  t_cmd_entry  i_q_entry,
    output logic        o_q_rd,
    input  logic        i_pop,
    output logic        o_empty,
    output t_phase      o_phase
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } t_state;

    t_state              r_state, n_state;
    t_cmd_entry          r_cmd;
    logic [PHASE_W-1:0]  r_phase, n_phase;
    logic [15:0]         r_hold, n_hold;
    logic                r_out_valid, n_out_valid;
    t_phase              r_out;
    t_phase              w_cur;
    logic                w_out_free, w_emit, w_load;

    assign w_cur      = phase_bits(r_cmd, r_phase);
    assign w_out_free = !r_out_valid || i_pop;
    assign w_emit     = (r_state == ST_RUN) && (r_hold == '0) && w_out_free;
    assign w_load     = (r_state == ST_IDLE) && !i_q_empty;
    assign o_q_rd     = w_load;
    assign o_empty    = !r_out_valid;
    assign o_phase    = r_out;

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_hold      = r_hold;
        n_out_valid = r_out_valid;
        if (i_pop) begin
            n_out_valid = 1'b0;
        end
        if (r_hold != '0) begin
            n_hold = r_hold - 1'b1;
        end
        case (r_state)
            ST_IDLE: begin
                // last phase of the previous command keeps its hold
                if (w_load) begin
                    n_state = ST_RUN;
                    n_phase = '0;
                end
            end
            ST_RUN: begin
                if (w_emit) begin
                    n_out_valid = 1'b1;
                    n_phase     = r_phase + 1'b1;
                    // a zero delay holds like a delay of one
                    n_hold      = (i_delay == '0) ? '0 : i_delay - 1'b1;
                    if (w_cur.last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= '0;
            r_hold      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_hold      <= n_hold;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_cmd <= i_q_entry;
        end
        if (w_emit) begin
            r_out <= w_cur;
        end
    end

endmodule

@@ sv/i2c_master_byte_writer_core.sv @@
// I2C master byte writer: command queue, phase sequencer and APB delay register.
// The first phase of a command reaches the result ports via the queue, command and output registers.
// The hold counter holds each phase for the phase delay, a zero delay like a one;
// a write is 18 phases, start and stop 3; the load cycle between commands hides
// under the last hold unless the delay is below 2. Result stalls add cycles.
// Commands queue up to QUEUE_DEPTH deep while the sequencer runs.
// Reset (synchronous, active low) empties queue and output, delay returns to 500.
`timescale 1ns / 1ps
module i2c_master_byte_writer_core import i2cbw_pkg::*; #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_op,
    input  logic [7:0]  i_data,
    input  logic        i_ack_level,
    output logic        empty,
    input  logic        pop,
    output logic        o_scl,
    output logic        o_sda,
    output logic        o_sda_released,
    output logic        o_acked,
    output logic        o_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [15:0] r_delay;
    logic        w_q_full, w_q_empty, w_q_wr, w_q_rd, w_cfg_wr;
    t_cmd_entry  w_q_wr_entry, w_q_rd_entry;
    t_phase      w_phase;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
    assign prdata   = (paddr[2] == 1'b0) ? {16'b0, r_delay} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay <= DELAY_RESET;
        end else if (w_cfg_wr) begin
            r_delay <= pwdata[15:0];
        end
    end

    i2cbw_front u_front (
        .i_push      (push),
        .i_op        (i_op),
        .i_data      (i_data),
        .i_ack_level (i_ack_level),
        .i_q_full    (w_q_full),
        .o_full      (full),
        .o_q_wr      (w_q_wr),
        .o_q_entry   (w_q_wr_entry)
    );

    i2cbw_cmd_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (w_q_wr),
        .i_wr_entry (w_q_wr_entry),
        .i_rd       (w_q_rd),
        .o_rd_entry (w_q_rd_entry),
        .o_full     (w_q_full),
        .o_empty    (w_q_empty)
    );

    i2cbw_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_delay   (r_delay),
        .i_q_empty (w_q_empty),
        .i_q_entry (w_q_rd_entry),
        .o_q_rd    (w_q_rd),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_phase   (w_phase)
    );

    assign o_scl          = w_phase.scl;
    assign o_sda          = w_phase.sda;
    assign o_sda_released = w_phase.sda_released;
    assign o_acked        = w_phase.acked;
    assign o_last         = w_phase.last;

    a_ack_clock_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_sda_released) |-> (o_scl && !o_last))
        else $error("released SDA outside ninth clock high");

    a_acked_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_acked) |-> (o_last && !o_scl && !o_sda_released))
        else $error("ack reported outside last write phase");

    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> empty)
        else $error("result pending right after reset");

    a_no_emit_while_full_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> !empty && $stable(w_phase))
        else $error("pending result overwritten");

endmodule

@@ tb/i2c_master_byte_writer_core_test.sv @@
// Testbench for the I2C byte writer: commands in, pin phases out, checked against a line model.
`timescale 1ns / 1ps
module i2c_master_byte_writer_core_test;
    import i2cbw_pkg::*;

    localparam logic [1:0] OP_UNUSED       = 2'd3;
    localparam logic [2:0] ADDR_PHASE_DELAY = 3'd0;
    localparam int unsigned CYCLE_LIMIT    = 3_000_000;

    class phase_tracker;
        t_phase pending_phases[$];
        logic   scl_q = 1'b1;
        logic   sda_q = 1'b1;
        logic   rel_q = 1'b0;
        int     errors = 0;

        function void emit_phase(logic acked, logic last);
            t_phase p;
            p.scl          = scl_q;
            p.sda          = sda_q;
            p.sda_released = rel_q;
            p.acked        = acked;
            p.last         = last;
            pending_phases.push_back(p);
        endfunction

        // Line sequence produced by one accepted command.
        function void add_command(logic [1:0] op, logic [7:0] data, logic ack_level);
            logic [7:0] shift;
            case (op)
                OP_START: begin
                    sda_q = 1'b1; scl_q = 1'b1; emit_phase(1'b0, 1'b0);
                    sda_q = 1'b0; emit_phase(1'b0, 1'b0);
                    scl_q = 1'b0; emit_phase(1'b0, 1'b1);
                end
                OP_STOP: begin
                    scl_q = 1'b0; sda_q = 1'b0; emit_phase(1'b0, 1'b0);
                    scl_q = 1'b1; emit_phase(1'b0, 1'b0);
                    sda_q = 1'b1; emit_phase(1'b0, 1'b1);
                end
                OP_WRITE: begin
                    shift = data;
                    for (int i = 0; i < 8; i++) begin
                        sda_q = shift[7];
                        scl_q = 1'b1; emit_phase(1'b0, 1'b0);
                        scl_q = 1'b0; emit_phase(1'b0, 1'b0);
                        shift = shift << 1;
                    end
                    rel_q = 1'b1; scl_q = 1'b1; emit_phase(1'b0, 1'b0);
                    scl_q = 1'b0; rel_q = 1'b0; emit_phase(!ack_level, 1'b1);
                end
                default: ;
            endcase
        endfunction

        function void report_field(string name, logic want, logic got);
            if (got !== want) begin
                $display("%0t: %s expected %0b got %0b", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_phase(t_phase got);
            t_phase want;
            if (pending_phases.size() == 0) begin
                $display("%0t: unexpected beat, expected none got %b", $time, got);
                errors++;
                return;
            end
            want = pending_phases.pop_front();
            report_field("scl", want.scl, got.scl);
            report_field("sda", want.sda, got.sda);
            report_field("sda_released", want.sda_released, got.sda_released);
            report_field("acked", want.acked, got.acked);
            report_field("last", want.last, got.last);
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [1:0]  i_op = '0;
    logic [7:0]  i_data = '0;
    logic        i_ack_level = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic        o_scl;
    logic        o_sda;
    logic        o_sda_released;
    logic        o_acked;
    logic        o_last;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    phase_tracker book = new();
    int unsigned  cycles = 0;
    int           cur_delay = DELAY_RESET;
    logic         calm = 1'b0;
    int           stall_left = 0;

    i2c_master_byte_writer_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_op           (i_op),
        .i_data         (i_data),
        .i_ack_level    (i_ack_level),
        .empty          (empty),
        .pop            (pop),
        .o_scl          (o_scl),
        .o_sda          (o_sda),
        .o_sda_released (o_sda_released),
        .o_acked        (o_acked),
        .o_last         (o_last),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Result side: pop with random stalls, check every beat.
    initial begin
        t_phase got;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && pop && !empty) begin
                got = '{o_scl, o_sda, o_sda_released, o_acked, o_last};
                book.check_phase(got);
                stall_left = pick_gap();
            end
            if (stall_left > 0) begin
                pop <= 1'b0;
                stall_left--;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    task automatic send_command(logic [1:0] op, logic [7:0] data, logic ack_level);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push        <= 1'b1;
        i_op        <= op;
        i_data      <= data;
        i_ack_level <= ack_level;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        book.add_command(op, data, ack_level);
    endtask

    // Drain, let the last phase hold run out, then write the delay register.
    task automatic set_phase_delay(logic [15:0] value);
        push <= 1'b0;
        while (book.pending_phases.size() != 0) @(posedge i_clk);
        repeat ((cur_delay > 0 ? cur_delay : 1) + 40) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_PHASE_DELAY;
        pwdata  <= {16'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        cur_delay = value;
    endtask

    // Mostly framed transfers (start, writes, stop) with stray commands mixed in.
    task automatic random_traffic(int count);
        int sent;
        int burst;
        logic [1:0] op;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(0, 99) < 80) begin
                send_command(OP_START, $urandom_range(0, 255), $urandom_range(0, 1));
                burst = $urandom_range(1, 4);
                repeat (burst) begin
                    send_command(OP_WRITE, $urandom_range(0, 255), $urandom_range(0, 1));
                end
                send_command(OP_STOP, $urandom_range(0, 255), $urandom_range(0, 1));
                sent += burst + 2;
            end else begin
                op = $urandom_range(0, 3);
                send_command(op, $urandom_range(0, 255), $urandom_range(0, 1));
                if (op != OP_UNUSED) sent++;
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset delay
        send_command(OP_START, 8'h00, 1'b0);
        send_command(OP_WRITE, $urandom_range(0, 255), 1'b0);
        send_command(OP_STOP, 8'hFF, 1'b1);

        // zero delay, directed corners
        set_phase_delay(16'd0);
        send_command(OP_START, 8'hFF, 1'b1);
        send_command(OP_WRITE, 8'h00, 1'b0);
        send_command(OP_WRITE, 8'hFF, 1'b1);
        send_command(OP_WRITE, 8'h80, 1'b0);
        send_command(OP_WRITE, 8'h01, 1'b1);
        send_command(OP_WRITE, 8'hA5, 1'b0);
        send_command(OP_WRITE, 8'h5A, 1'b1);
        send_command(OP_UNUSED, 8'hFF, 1'b1);
        send_command(OP_STOP, 8'h00, 1'b0);
        send_command(OP_STOP, 8'h55, 1'b1);
        send_command(OP_START, 8'hAA, 1'b0);
        send_command(OP_START, 8'h00, 1'b1);
        send_command(OP_UNUSED, 8'h00, 1'b0);
        send_command(OP_WRITE, 8'h7F, 1'b0);
        send_command(OP_WRITE, 8'hFE, 1'b1);
        send_command(OP_STOP, 8'hFF, 1'b0);

        set_phase_delay(16'd1);
        random_traffic(20);
        calm = 1'b1;
        set_phase_delay(16'd2);
        random_traffic(20);
        calm = 1'b0;
        set_phase_delay($urandom_range(3, 20));
        random_traffic(20);
        set_phase_delay(16'd0);
        random_traffic(20);
        calm = 1'b1;
        set_phase_delay(16'd1);
        random_traffic(10);
        calm = 1'b0;
        set_phase_delay($urandom_range(2, 8));
        random_traffic(10);

        // longest hold, kept to a single short command
        set_phase_delay(16'hFFFF);
        send_command(OP_START, $urandom_range(0, 255), $urandom_range(0, 1));
        send_command(OP_UNUSED, $urandom_range(0, 255), $urandom_range(0, 1));
        push <= 1'b0;

        while (book.pending_phases.size() != 0) @(posedge i_clk);
        repeat ((cur_delay > 0 ? cur_delay : 1) + 40) @(posedge i_clk);
        if (book.errors == 0 && book.pending_phases.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
